// File: rtl/hsu_pkg.sv
// shared types, codes and helpers for the two-limit homing sequencer
package hsu_pkg;

  // command codes carried by cmd
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // motion command codes
  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_STOP = 2'd1;
  localparam logic [1:0] OP_REL  = 2'd2;
  localparam logic [1:0] OP_ABS  = 2'd3;

  // phase codes as reported on the phase output
  localparam logic [3:0] PH_IDLE         = 4'd0;
  localparam logic [3:0] PH_SEEK_LO_FAST = 4'd1;
  localparam logic [3:0] PH_BACK_LO      = 4'd2;
  localparam logic [3:0] PH_SEEK_LO_SLOW = 4'd3;
  localparam logic [3:0] PH_CLEAR_LO     = 4'd4;
  localparam logic [3:0] PH_SEEK_HI_FAST = 4'd5;
  localparam logic [3:0] PH_BACK_HI      = 4'd6;
  localparam logic [3:0] PH_SEEK_HI_SLOW = 4'd7;
  localparam logic [3:0] PH_CLEAR_HI     = 4'd8;
  localparam logic [3:0] PH_DONE         = 4'd9;
  localparam logic [3:0] PH_ERROR        = 4'd10;

  // configuration register indexes
  localparam int CFG_INDEX_BITS = 3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TIMEOUT  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DEBOUNCE = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BACKOFF  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CLEAR    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SEEK     = 3'd4;

  // configuration reset values
  localparam logic [31:0] TIMEOUT_RESET  = 32'd30000;
  localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
  localparam logic [19:0] BACKOFF_RESET  = 20'd200;
  localparam logic [19:0] CLEAR_RESET    = 20'd50;
  localparam logic [29:0] SEEK_RESET     = 30'd1000000;

  typedef enum logic [10:0] {
    ST_IDLE         = 11'b000_0000_0001,
    ST_SEEK_LO_FAST = 11'b000_0000_0010,
    ST_BACK_LO      = 11'b000_0000_0100,
    ST_SEEK_LO_SLOW = 11'b000_0000_1000,
    ST_CLEAR_LO     = 11'b000_0001_0000,
    ST_SEEK_HI_FAST = 11'b000_0010_0000,
    ST_BACK_HI      = 11'b000_0100_0000,
    ST_SEEK_HI_SLOW = 11'b000_1000_0000,
    ST_CLEAR_HI     = 11'b001_0000_0000,
    ST_DONE         = 11'b010_0000_0000,
    ST_ERROR        = 11'b100_0000_0000
  } state_t;

  typedef struct packed {
    logic [31:0] timeout_ms;
    logic [15:0] settle_ms;
    logic [19:0] backoff_len;
    logic [19:0] clear_steps;
    logic [29:0] seek_travel;
  } cfg_t;

  typedef struct packed {
    state_t      phase;
    logic [31:0] start_stamp;
    logic [31:0] settle_stamp;
    logic        driver_enabled;
    logic        homed;
    logic        pos_valid;
    logic [31:0] span;
  } ctx_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [30:0] distance;
    logic        fast;
    logic        zero;
  } cmd_t;

  function automatic logic [3:0] phase_code(state_t s);
    logic [3:0] code;
    case (s)
      ST_IDLE:         code = PH_IDLE;
      ST_SEEK_LO_FAST: code = PH_SEEK_LO_FAST;
      ST_BACK_LO:      code = PH_BACK_LO;
      ST_SEEK_LO_SLOW: code = PH_SEEK_LO_SLOW;
      ST_CLEAR_LO:     code = PH_CLEAR_LO;
      ST_SEEK_HI_FAST: code = PH_SEEK_HI_FAST;
      ST_BACK_HI:      code = PH_BACK_HI;
      ST_SEEK_HI_SLOW: code = PH_SEEK_HI_SLOW;
      ST_CLEAR_HI:     code = PH_CLEAR_HI;
      ST_DONE:         code = PH_DONE;
      default:         code = PH_ERROR;
    endcase
    return code;
  endfunction

endpackage

// File: rtl/hsu_step.sv
// next-state and motion command logic for one homing item
module hsu_step #(
  parameter int POSITION_BITS = 32
) (
  input  logic               cmd,
  input  logic [31:0]        now_ms,
  input  logic               limit_low,
  input  logic               limit_high,
  input  logic               move_done,
  input  logic signed [31:0] current_position,
  input  hsu_pkg::cfg_t      cfg,
  input  hsu_pkg::ctx_t      cur,
  output hsu_pkg::ctx_t      nxt,
  output hsu_pkg::cmd_t      res
);

  // span is the position wrapped to POSITION_BITS, sign extended back to 32
  localparam int SIGN_BIT = (POSITION_BITS < 32) ? POSITION_BITS - 1 : 31;

  logic [31:0] span_fit;
  logic [31:0] elapsed;
  logic [31:0] settle_elapsed;
  logic        active;
  logic [30:0] seek_pos;
  logic [30:0] seek_neg;
  logic [30:0] back_pos;
  logic [30:0] back_neg;
  logic [30:0] clear_pos;
  logic [30:0] clear_neg;

  always_comb begin
    for (int i = 0; i < 32; i++) begin
      span_fit[i] = (i <= SIGN_BIT) ? current_position[i] : current_position[SIGN_BIT];
    end
  end

  assign elapsed        = now_ms - cur.start_stamp;
  assign settle_elapsed = now_ms - cur.settle_stamp;

  assign seek_pos  = {1'b0, cfg.seek_travel};
  assign seek_neg  = 31'd0 - seek_pos;
  assign back_pos  = {11'd0, cfg.backoff_len};
  assign back_neg  = 31'd0 - back_pos;
  assign clear_pos = {11'd0, cfg.clear_steps};
  assign clear_neg = 31'd0 - clear_pos;

  assign active = !(cur.phase == hsu_pkg::ST_IDLE || cur.phase == hsu_pkg::ST_DONE ||
                    cur.phase == hsu_pkg::ST_ERROR);

  always_comb begin
    nxt          = cur;
    res.op       = hsu_pkg::OP_NONE;
    res.distance = '0;
    res.fast     = 1'b0;
    res.zero     = 1'b0;
    if (cmd == hsu_pkg::CMD_START) begin
      nxt.driver_enabled = 1'b1;
      nxt.homed          = 1'b0;
      nxt.pos_valid      = 1'b0;
      nxt.span           = '0;
      nxt.start_stamp    = now_ms;
      nxt.phase          = hsu_pkg::ST_SEEK_LO_FAST;
      res.op             = hsu_pkg::OP_ABS;
      res.distance       = seek_neg;
      res.fast           = 1'b1;
    end else if (active && elapsed >= cfg.timeout_ms) begin
      res.op             = hsu_pkg::OP_STOP;
      nxt.driver_enabled = 1'b0;
      nxt.homed          = 1'b0;
      nxt.pos_valid      = 1'b0;
      nxt.phase          = hsu_pkg::ST_ERROR;
    end else begin
      case (cur.phase)
        hsu_pkg::ST_IDLE, hsu_pkg::ST_DONE, hsu_pkg::ST_ERROR: begin
        end
        hsu_pkg::ST_SEEK_LO_FAST: begin
          if (limit_low) begin
            res.op       = hsu_pkg::OP_REL;
            res.distance = back_pos;
            nxt.phase    = hsu_pkg::ST_BACK_LO;
          end
        end
        hsu_pkg::ST_BACK_LO: begin
          if (move_done) begin
            res.op       = hsu_pkg::OP_REL;
            res.distance = seek_neg;
            nxt.phase    = hsu_pkg::ST_SEEK_LO_SLOW;
          end
        end
        hsu_pkg::ST_SEEK_LO_SLOW: begin
          if (limit_low) begin
            res.op           = hsu_pkg::OP_REL;
            res.distance     = clear_pos;
            nxt.settle_stamp = now_ms;
            nxt.phase        = hsu_pkg::ST_CLEAR_LO;
          end
        end
        hsu_pkg::ST_CLEAR_LO: begin
          // settle time restarts while the clear move is still running
          if (!move_done) begin
            nxt.settle_stamp = now_ms;
          end else if (settle_elapsed >= {16'd0, cfg.settle_ms}) begin
            res.zero     = 1'b1;
            res.op       = hsu_pkg::OP_ABS;
            res.distance = seek_pos;
            res.fast     = 1'b1;
            nxt.phase    = hsu_pkg::ST_SEEK_HI_FAST;
          end
        end
        hsu_pkg::ST_SEEK_HI_FAST: begin
          if (limit_high) begin
            res.op       = hsu_pkg::OP_REL;
            res.distance = back_neg;
            nxt.phase    = hsu_pkg::ST_BACK_HI;
          end
        end
        hsu_pkg::ST_BACK_HI: begin
          if (move_done) begin
            res.op       = hsu_pkg::OP_REL;
            res.distance = seek_pos;
            nxt.phase    = hsu_pkg::ST_SEEK_HI_SLOW;
          end
        end
        hsu_pkg::ST_SEEK_HI_SLOW: begin
          if (limit_high) begin
            res.op           = hsu_pkg::OP_REL;
            res.distance     = clear_neg;
            nxt.settle_stamp = now_ms;
            nxt.phase        = hsu_pkg::ST_CLEAR_HI;
          end
        end
        hsu_pkg::ST_CLEAR_HI: begin
          if (!move_done) begin
            nxt.settle_stamp = now_ms;
          end else if (settle_elapsed >= {16'd0, cfg.settle_ms}) begin
            nxt.span           = span_fit;
            nxt.phase          = hsu_pkg::ST_DONE;
            nxt.homed          = 1'b1;
            nxt.pos_valid      = 1'b1;
            nxt.driver_enabled = 1'b0;
          end
        end
        default: begin
          // corrupted state encoding
          res.op             = hsu_pkg::OP_STOP;
          nxt.driver_enabled = 1'b0;
          nxt.homed          = 1'b0;
          nxt.pos_valid      = 1'b0;
          nxt.phase          = hsu_pkg::ST_ERROR;
        end
      endcase
    end
  end

endmodule

// File: rtl/two_limit_homing_sequencer_unit.sv
// top level of the two-limit stepper homing sequencer
//
// Usage: send a start item (cmd 0) to enable the driver and begin a fast
// seek toward the lower limit, then send tick items (cmd 1) carrying the
// millisecond time, both limit switches, move_done and the engine position.
// Every accepted item produces exactly one result item: the motion command
// for that item plus the phase, flags, driver enable and recorded span.
// Input and result channels use valid/ready; a transfer happens when both
// are high. Configuration registers are written through the cfg channel
// (cfg_ready is always high); the user must write them only while no item
// is in flight, as the block itself does not enforce this. Each item is
// captured in the input register, then its result in the result register.
// Throughput: one item per cycle while the receiver accepts results, set by
// the single state update stage between the two registers.
// When the receiver stalls, the result register holds and the input
// register fills; in_ready drops only once both are occupied.
// Reset returns the sequencer to idle with flags cleared, the driver off
// and all configuration registers at their default values.
module two_limit_homing_sequencer_unit #(
  parameter int POSITION_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               cmd,
  input  logic [31:0]                        now_ms,
  input  logic                               limit_low,
  input  logic                               limit_high,
  input  logic                               move_done,
  input  logic signed [31:0]                 current_position,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         motion_op,
  output logic signed [30:0]                 motion_distance,
  output logic                               fast_speed,
  output logic                               zero_position,
  output logic                               driver_on,
  output logic [3:0]                         phase,
  output logic                               is_homed,
  output logic                               position_valid,
  output logic signed [31:0]                 travel_span,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [hsu_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [31:0]                        cfg_data
);

  hsu_pkg::cfg_t cfg;
  hsu_pkg::ctx_t ctx;
  hsu_pkg::ctx_t ctx_next;
  hsu_pkg::cmd_t res;

  // input register
  logic               s1_valid;
  logic               s1_cmd;
  logic [31:0]        s1_now_ms;
  logic               s1_limit_low;
  logic               s1_limit_high;
  logic               s1_move_done;
  logic signed [31:0] s1_position;
  logic               s2_load;

  assign cfg_ready = 1'b1;
  assign s2_load   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || s2_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ms  <= hsu_pkg::TIMEOUT_RESET;
      cfg.settle_ms   <= hsu_pkg::DEBOUNCE_RESET;
      cfg.backoff_len <= hsu_pkg::BACKOFF_RESET;
      cfg.clear_steps <= hsu_pkg::CLEAR_RESET;
      cfg.seek_travel <= hsu_pkg::SEEK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hsu_pkg::CFG_TIMEOUT:  cfg.timeout_ms  <= cfg_data;
        hsu_pkg::CFG_DEBOUNCE: cfg.settle_ms   <= cfg_data[15:0];
        hsu_pkg::CFG_BACKOFF:  cfg.backoff_len <= cfg_data[19:0];
        hsu_pkg::CFG_CLEAR:    cfg.clear_steps <= cfg_data[19:0];
        hsu_pkg::CFG_SEEK:     cfg.seek_travel <= cfg_data[29:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s2_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd        <= cmd;
      s1_now_ms     <= now_ms;
      s1_limit_low  <= limit_low;
      s1_limit_high <= limit_high;
      s1_move_done  <= move_done;
      s1_position   <= current_position;
    end
  end

  hsu_step #(
    .POSITION_BITS(POSITION_BITS)
  ) u_step (
    .cmd              (s1_cmd),
    .now_ms           (s1_now_ms),
    .limit_low        (s1_limit_low),
    .limit_high       (s1_limit_high),
    .move_done        (s1_move_done),
    .current_position (s1_position),
    .cfg              (cfg),
    .cur              (ctx),
    .nxt              (ctx_next),
    .res              (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx.phase          <= hsu_pkg::ST_IDLE;
      ctx.start_stamp    <= '0;
      ctx.settle_stamp   <= '0;
      ctx.driver_enabled <= 1'b0;
      ctx.homed          <= 1'b0;
      ctx.pos_valid      <= 1'b0;
      ctx.span           <= '0;
      out_valid          <= 1'b0;
    end else if (s2_load) begin
      ctx       <= ctx_next;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (s2_load) begin
      motion_op       <= res.op;
      motion_distance <= res.distance;
      fast_speed      <= res.fast;
      zero_position   <= res.zero;
      driver_on       <= ctx_next.driver_enabled;
      phase           <= hsu_pkg::phase_code(ctx_next.phase);
      is_homed        <= ctx_next.homed;
      position_valid  <= ctx_next.pos_valid;
      travel_span     <= ctx_next.span;
    end
  end

  a_done_flags: assert property (@(posedge clk) disable iff (rst)
    (out_valid && phase == hsu_pkg::PH_DONE) |-> (!driver_on && is_homed && position_valid))
    else $error("done result without homed flags or with driver enabled");

  a_error_flags: assert property (@(posedge clk) disable iff (rst)
    (out_valid && phase == hsu_pkg::PH_ERROR) |-> (!driver_on && !is_homed && !position_valid))
    else $error("error result with driver or flags still set");

  a_start_seek: assert property (@(posedge clk) disable iff (rst)
    (s2_load && s1_cmd == hsu_pkg::CMD_START) |=>
      (out_valid && phase == hsu_pkg::PH_SEEK_LO_FAST && driver_on &&
       motion_op == hsu_pkg::OP_ABS && fast_speed))
    else $error("start transfer did not launch the fast lower seek");

  a_idle_cmd: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (motion_op == hsu_pkg::OP_NONE || motion_op == hsu_pkg::OP_STOP)) |->
      (motion_distance == '0 && !fast_speed))
    else $error("none or stop command carries distance or speed");

endmodule
